FILE: rtl/mase_pkg.sv
// ----------------------------------------------------------------------------
// mase_pkg: shared constants of the matrix add/sub/mul engine.
// Holds command and operation codes and the register indexes.
// ----------------------------------------------------------------------------
package mase_pkg;

    localparam int unsigned FuncW = 2;
    localparam int unsigned PosW  = 4;
    localparam int unsigned DataW = 32;
    localparam int unsigned DimW  = 5;
    localparam int unsigned CfgIdxW = 3;

    // Largest matrix side; the row and column fields hold exactly this range.
    localparam int unsigned MaxDim = 16;

    localparam logic [FuncW-1:0] FUNC_WRITE_A = 2'd0;
    localparam logic [FuncW-1:0] FUNC_WRITE_B = 2'd1;
    localparam logic [FuncW-1:0] FUNC_COMPUTE = 2'd2;
    localparam logic [FuncW-1:0] FUNC_READ    = 2'd3;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_OPERATION = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ROWS_A    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_COLS_A    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ROWS_B    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_COLS_B    = 3'd4;

endpackage

FILE: rtl/matrix_add_sub_mul_engine_top.sv
// ----------------------------------------------------------------------------
// matrix_add_sub_mul_engine_top: integer matrix add, subtract and multiply.
// Three 32-bit element memories, a sequencer for compute and flag checks.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                       Content
// s_axis    in   s_tvalid/s_tready/s_tdata     func, row, col, value
// m_axis    out  m_tvalid/m_tready/m_tdata     element, flags
// cfg       in   cfg_we/cfg_index/cfg_wdata    operation and dimensions
//
// Element writes are taken at one item per cycle when the output is free; a
// read holds off the next item until the registered result memory answers.
// A compute runs an arithmetic pass, each inner step a read of A and B
// (S_RD) then an accumulate (S_ACC) and each element ending in S_WR, then a
// flag pass of S_CHK_A, S_CHK_B and S_CHK_C per element. A compute with
// mismatched dimensions answers on the next cycle.
// aresetn is synchronous and active low; the stores need no clearing.
// While a compute or a read is under way, or the output register is full and not being taken, s_tready is low.
// ----------------------------------------------------------------------------
module matrix_add_sub_mul_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] func, [5:2] row, [9:6] col, [41:10] value, [47:42] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] element, [32] is_symmetric, [33] is_upper_triangular,
    // [34] dims_error, [39:35] zero
    output logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_wdata
);
    localparam int unsigned MAX_DIM = mase_pkg::MaxDim;
    localparam int unsigned IW    = $clog2(MAX_DIM);
    localparam int unsigned AW    = 2 * IW;
    localparam int unsigned CELLS = MAX_DIM * MAX_DIM;
    localparam int unsigned CW    = $clog2(MAX_DIM + 1);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RD     = 7'b0000010,
        S_ACC    = 7'b0000100,
        S_WR     = 7'b0001000,
        S_CHK_A  = 7'b0010000,
        S_CHK_B  = 7'b0100000,
        S_CHK_C  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0] op_reg;
    logic [4:0] ra_reg, ca_reg, rb_reg, cb_reg;

    logic [31:0] mem_a [CELLS];
    logic [31:0] mem_b [CELLS];
    logic [31:0] mem_r [CELLS];

    logic [31:0] a_q, b_q, r_q;
    logic [AW-1:0] a_addr, b_addr, r_addr;

    logic sym_reg, tri_reg, err_reg;
    logic [31:0] acc_reg, first_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic read_pend_reg;
    logic m_valid_reg;
    logic [31:0] m_elem_reg;

    // Input fields.
    logic [1:0] in_func;
    logic [3:0] in_row, in_col;
    logic [31:0] in_value;
    assign in_func  = s_tdata[1:0];
    assign in_row   = s_tdata[5:2];
    assign in_col   = s_tdata[9:6];
    assign in_value = s_tdata[41:10];

    function automatic logic [CW-1:0] clampd(input logic [4:0] d);
        logic [CW-1:0] r;
        if (d == 5'd0) r = CW'(1);
        else if (32'(d) > MAX_DIM) r = CW'(MAX_DIM);
        else r = CW'(d);
        return r;
    endfunction

    logic [CW-1:0] ra, ca, rb, cb, rr, rc, kn;
    logic mul, mismatch;
    assign ra = clampd(ra_reg);
    assign ca = clampd(ca_reg);
    assign rb = clampd(rb_reg);
    assign cb = clampd(cb_reg);
    assign mul = op_reg[1];
    assign mismatch = mul ? (ca != rb) : (ra != rb || ca != cb);
    assign rr = ra;
    assign rc = mul ? cb : ca;
    assign kn = mul ? ca : CW'(1);

    logic in_range;
    assign in_range = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);

    logic idle_ok, accept;
    assign idle_ok  = (state_reg == S_IDLE) && !read_pend_reg
                   && (!m_valid_reg || m_tready);
    assign s_tready = idle_ok;
    assign accept   = s_tvalid && idle_ok;

    logic last_k, last_j, last_i;
    assign last_k = (CW'(k_reg) + CW'(1)) == kn;
    assign last_j = (CW'(j_reg) + CW'(1)) == rc;
    assign last_i = (CW'(i_reg) + CW'(1)) == rr;

    // Address selection for the shared read ports.
    always_comb begin
        a_addr = {i_reg, k_reg};
        b_addr = mul ? {k_reg, j_reg} : {i_reg, j_reg};
        r_addr = {i_reg, j_reg};
        if (state_reg == S_IDLE) begin
            r_addr = {in_row[IW-1:0], in_col[IW-1:0]};
        end else if (state_reg == S_CHK_A) begin
            r_addr = {j_reg, i_reg};
        end
        if (!mul) a_addr = {i_reg, j_reg};
    end

    // Memories.
    logic wr_r;
    logic [31:0] prod;
    assign prod = a_q * b_q;
    always_ff @(posedge aclk) begin
        if (accept && in_func == mase_pkg::FUNC_WRITE_A && in_range)
            mem_a[{in_row[IW-1:0], in_col[IW-1:0]}] <= in_value;
        if (accept && in_func == mase_pkg::FUNC_WRITE_B && in_range)
            mem_b[{in_row[IW-1:0], in_col[IW-1:0]}] <= in_value;
        if (wr_r) mem_r[{i_reg, j_reg}] <= acc_reg;
        a_q <= mem_a[a_addr];
        b_q <= mem_b[b_addr];
        r_q <= mem_r[r_addr];
    end
    assign wr_r = (state_reg == S_WR);

    logic read_inside_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept && in_func == mase_pkg::FUNC_COMPUTE && !mismatch)
                         state_next = S_RD;
            S_RD:    state_next = S_ACC;
            S_ACC:   state_next = last_k ? S_WR : S_RD;
            S_WR:    state_next = (last_j && last_i) ? S_CHK_A : S_RD;
            S_CHK_A: state_next = S_CHK_B;
            S_CHK_B: state_next = S_CHK_C;
            S_CHK_C: state_next = (last_j && last_i) ? S_IDLE : S_CHK_A;
            default: state_next = S_IDLE;
        endcase
    end

    // A result is raised by a write, a mismatched compute, the cycle after a
    // read, or the end of the flag pass; otherwise it stays until taken.
    logic m_valid_next;
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        if (accept && (in_func == mase_pkg::FUNC_WRITE_A
                    || in_func == mase_pkg::FUNC_WRITE_B))
            m_valid_next = 1'b1;
        if (accept && in_func == mase_pkg::FUNC_COMPUTE && mismatch)
            m_valid_next = 1'b1;
        if (read_pend_reg) m_valid_next = 1'b1;
        if (state_reg == S_CHK_C && last_j && last_i) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg <= mase_pkg::OP_MUL;
            ra_reg <= 5'd1; ca_reg <= 5'd1; rb_reg <= 5'd1; cb_reg <= 5'd1;
            sym_reg <= 1'b0; tri_reg <= 1'b0; err_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            read_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            read_pend_reg <= accept && (in_func == mase_pkg::FUNC_READ);
            if (cfg_we) begin
                unique case (cfg_index)
                    mase_pkg::REG_OPERATION: op_reg <= cfg_wdata[1:0];
                    mase_pkg::REG_ROWS_A:    ra_reg <= cfg_wdata;
                    mase_pkg::REG_COLS_A:    ca_reg <= cfg_wdata;
                    mase_pkg::REG_ROWS_B:    rb_reg <= cfg_wdata;
                    mase_pkg::REG_COLS_B:    cb_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept && in_func == mase_pkg::FUNC_COMPUTE) begin
                if (mismatch) begin
                    err_reg <= 1'b1; sym_reg <= 1'b0; tri_reg <= 1'b0;
                end else begin
                    err_reg <= 1'b0; sym_reg <= (rr == rc);
                    tri_reg <= 1'b1;
                end
            end
            if (state_reg == S_CHK_C) begin
                if (i_reg > j_reg && r_q != 32'd0) tri_reg <= 1'b0;
                if (j_reg > i_reg && first_reg != r_q) sym_reg <= 1'b0;
            end
        end
    end

    // Datapath counters and accumulator.
    always_ff @(posedge aclk) begin
        if (accept) begin
            i_reg <= '0; j_reg <= '0; k_reg <= '0; acc_reg <= '0;
            read_inside_reg <= in_range;
            m_elem_reg <= 32'd0;
        end
        if (read_pend_reg) m_elem_reg <= read_inside_reg ? r_q : 32'd0;
        unique case (state_reg)
            S_ACC: begin
                if (mul) acc_reg <= acc_reg + prod;
                else if (op_reg == mase_pkg::OP_ADD) acc_reg <= a_q + b_q;
                else acc_reg <= a_q - b_q;
                if (!last_k) k_reg <= k_reg + IW'(1);
            end
            S_WR: begin
                acc_reg <= '0; k_reg <= '0;
                if (last_j) begin
                    j_reg <= '0;
                    if (!last_i) i_reg <= i_reg + IW'(1);
                    else i_reg <= '0;
                end else j_reg <= j_reg + IW'(1);
            end
            S_CHK_B: first_reg <= r_q;
            S_CHK_C: begin
                if (last_j) begin
                    j_reg <= '0;
                    if (!last_i) i_reg <= i_reg + IW'(1);
                end else j_reg <= j_reg + IW'(1);
            end
            default: ;
        endcase
    end

    // S_CHK_A reads (j,i); S_CHK_B reads (i,j) into r_q while storing (j,i).
    // In S_CHK_C first_reg holds (j,i) and r_q holds (i,j).

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, err_reg, tri_reg, sym_reg, m_elem_reg};
endmodule

FILE: rtl/mase_checker.sv
// ----------------------------------------------------------------------------
// mase_props: port-level checks of the matrix engine.
// Watches handshakes and flag consistency over time.
// ----------------------------------------------------------------------------
module mase_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No new item while a result waits unaccepted.
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // A mismatch never reports good flags.
    a_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> !m_tdata[32] && !m_tdata[33])
        else $error("flags set with dims error");

    // A write item returns a zero element.
    a_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tdata[1] |=> m_tvalid && m_tdata[31:0] == 32'd0)
        else $error("write item gave nonzero element");
endmodule

bind matrix_add_sub_mul_engine_top mase_props u_mase_props (.*);

FILE: bench/mase_checker.sv
// ----------------------------------------------------------------------------
// mase_checker: result predictor and comparator for the matrix engine.
// Watches the input, result and register ports, keeps its own copy of the
// three element stores and the flags, and checks every result item in order.
// ----------------------------------------------------------------------------
module mase_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_wdata,
    output int          fail_count,
    output int          outstanding
);

    localparam int Dim = int'(mase_pkg::MaxDim);

    typedef struct packed {
        logic [31:0] element;
        logic        symmetric;
        logic        upper;
        logic        dims_err;
    } answer_t;

    logic [31:0] a_mem [0:255];
    logic [31:0] b_mem [0:255];
    logic [31:0] r_mem [0:255];
    logic        sym_flag, upper_flag, err_flag;
    logic [1:0]  op_reg;
    logic [4:0]  ra_reg, ca_reg, rb_reg, cb_reg;
    answer_t     answer_q [$];

    function automatic int clamp_dim(logic [4:0] d);
        if (d == 0) return 1;
        if (d > Dim) return Dim;
        return int'(d);
    endfunction

    // Forms the result into r_mem, unless the dimensions mismatch, and updates the three flags.
    task automatic form_result();
        int ra, ca, rb, cb, rr, rc;
        logic mul;
        logic [31:0] acc;
        ra  = clamp_dim(ra_reg);
        ca  = clamp_dim(ca_reg);
        rb  = clamp_dim(rb_reg);
        cb  = clamp_dim(cb_reg);
        mul = op_reg[1];
        if (mul ? (ca != rb) : (ra != rb || ca != cb)) begin
            err_flag   = 1'b1;
            sym_flag   = 1'b0;
            upper_flag = 1'b0;
            return;
        end
        rr = ra;
        rc = mul ? cb : ca;
        for (int i = 0; i < rr; i++) begin
            for (int j = 0; j < rc; j++) begin
                if (mul) begin
                    acc = '0;
                    for (int k = 0; k < ca; k++)
                        acc += a_mem[i*Dim+k] * b_mem[k*Dim+j];
                end else if (op_reg == mase_pkg::OP_ADD) begin
                    acc = a_mem[i*Dim+j] + b_mem[i*Dim+j];
                end else begin
                    acc = a_mem[i*Dim+j] - b_mem[i*Dim+j];
                end
                r_mem[i*Dim+j] = acc;
            end
        end
        err_flag   = 1'b0;
        sym_flag   = (rr == rc);
        upper_flag = 1'b1;
        for (int i = 0; i < rr; i++) begin
            for (int j = 0; j < rc; j++) begin
                if (i > j && r_mem[i*Dim+j] != 0) upper_flag = 1'b0;
                if (rr == rc && j > i && r_mem[i*Dim+j] != r_mem[j*Dim+i])
                    sym_flag = 1'b0;
            end
        end
    endtask

    always @(posedge aclk) begin
        logic [1:0]  func;
        logic [3:0]  row, col;
        logic [31:0] value;
        answer_t     want, got;
        if (!aresetn) begin
            sym_flag    = 1'b0;
            upper_flag  = 1'b0;
            err_flag    = 1'b0;
            op_reg      = mase_pkg::OP_MUL;
            ra_reg      = 5'd1;
            ca_reg      = 5'd1;
            rb_reg      = 5'd1;
            cb_reg      = 5'd1;
            fail_count  = 0;
            answer_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mase_pkg::REG_OPERATION: op_reg = cfg_wdata[1:0];
                    mase_pkg::REG_ROWS_A:    ra_reg = cfg_wdata;
                    mase_pkg::REG_COLS_A:    ca_reg = cfg_wdata;
                    mase_pkg::REG_ROWS_B:    rb_reg = cfg_wdata;
                    mase_pkg::REG_COLS_B:    cb_reg = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[34]};
                if (answer_q.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end else begin
                    want = answer_q.pop_front();
                    if (got.element !== want.element) begin
                        $error("element: expected %h actual %h", want.element, got.element);
                        fail_count++;
                    end
                    if (got.symmetric !== want.symmetric) begin
                        $error("is_symmetric: expected %b actual %b",
                               want.symmetric, got.symmetric);
                        fail_count++;
                    end
                    if (got.upper !== want.upper) begin
                        $error("is_upper_triangular: expected %b actual %b",
                               want.upper, got.upper);
                        fail_count++;
                    end
                    if (got.dims_err !== want.dims_err) begin
                        $error("dims_error: expected %b actual %b",
                               want.dims_err, got.dims_err);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                func  = s_tdata[1:0];
                row   = s_tdata[5:2];
                col   = s_tdata[9:6];
                value = s_tdata[41:10];
                want.element = '0;
                case (func)
                    mase_pkg::FUNC_WRITE_A: a_mem[row*Dim+col] = value;
                    mase_pkg::FUNC_WRITE_B: b_mem[row*Dim+col] = value;
                    mase_pkg::FUNC_COMPUTE: form_result();
                    default:                want.element = r_mem[row*Dim+col];
                endcase
                want.symmetric = sym_flag;
                want.upper     = upper_flag;
                want.dims_err  = err_flag;
                answer_q.push_back(want);
            end
        end
        outstanding = answer_q.size();
    end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the matrix add/sub/mul engine.
// Loads matrices, runs computes under many dimension settings and reads the
// results back, with bursty input and a stalling receiver; mase_checker
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;

    // Operation code three is an alias of multiply.
    localparam logic [1:0] OpAlias = 2'd3;
    localparam int Dim        = int'(mase_pkg::MaxDim);
    localparam int TargetItems = 1450;
    // A full 16x16x16 multiply runs with no handshake until its flag pass ends;
    // the receiver's stalls are short, so this leaves a wide margin.
    localparam int IdleLimit  = 40000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [1:0] func, [5:2] row, [9:6] col, [41:10] value, [47:42] zero
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [31:0] element, [32] is_symmetric, [33] is_upper_triangular,
    // [34] dims_error, [39:35] zero
    logic [39:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [4:0]  cfg_wdata;

    int fail_count;
    int outstanding;
    int idle_cycles;
    int items_sent;
    int burst_left;

    // Which result entries hold a computed value; reads never touch others.
    bit r_valid [0:255];
    logic [1:0] cur_op;
    logic [4:0] cur_ra, cur_ca, cur_rb, cur_cb;

    matrix_add_sub_mul_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    mase_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // The receiver switches in turn between always ready, light stalls and
    // heavy stalls, so back pressure lands on every phase.
    always @(posedge aclk) begin
        int mode;
        mode = int'(($time / 128) % 3);
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    // Watchdog: any cycle without a handshake on either channel counts.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic int clamp_dim(logic [4:0] d);
        if (d == 0) return 1;
        if (d > Dim) return Dim;
        return int'(d);
    endfunction

    // Sends one item. The sender works in bursts; between bursts valid drops
    // for a random gap. Acceptance is judged from s_tready at the falling
    // edge, which is settled well before the next rising edge.
    task automatic send_item(logic [1:0] func, int row, int col,
                             logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, value, col[3:0], row[3:0], func};
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    // Issues a compute and records which result entries it fills.
    task automatic compute();
        int ra, ca, rb, cb, rc;
        ra = clamp_dim(cur_ra);
        ca = clamp_dim(cur_ca);
        rb = clamp_dim(cur_rb);
        cb = clamp_dim(cur_cb);
        send_item(mase_pkg::FUNC_COMPUTE, $urandom, $urandom, $urandom);
        if (cur_op[1] ? (ca == rb) : (ra == rb && ca == cb)) begin
            rc = cur_op[1] ? cb : ca;
            for (int i = 0; i < ra; i++)
                for (int j = 0; j < rc; j++)
                    r_valid[i*Dim+j] = 1'b1;
        end
    endtask

    // Reads back result entries, only ones that have been written.
    task automatic read_back(int count);
        int row, col, any;
        any = 0;
        for (int i = 0; i < 256; i++) any += int'(r_valid[i]);
        if (any == 0) return;
        repeat (count) begin
            do begin
                row = $urandom_range(0, Dim - 1);
                col = $urandom_range(0, Dim - 1);
                if (!r_valid[row*Dim+col] && $urandom_range(0, 1)) begin
                    row = 0;
                    col = 0;
                end
            end while (!r_valid[row*Dim+col]);
            send_item(mase_pkg::FUNC_READ, row, col, $urandom);
        end
    endtask

    // Drops valid, waits until every result has arrived and the block is
    // quiet, then writes all five registers on consecutive cycles.
    task automatic set_regs(logic [1:0] op, logic [4:0] ra, logic [4:0] ca,
                            logic [4:0] rb, logic [4:0] cb);
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= mase_pkg::REG_OPERATION;
        cfg_wdata <= {3'd0, op};
        @(posedge aclk);
        cfg_index <= mase_pkg::REG_ROWS_A;
        cfg_wdata <= ra;
        @(posedge aclk);
        cfg_index <= mase_pkg::REG_COLS_A;
        cfg_wdata <= ca;
        @(posedge aclk);
        cfg_index <= mase_pkg::REG_ROWS_B;
        cfg_wdata <= rb;
        @(posedge aclk);
        cfg_index <= mase_pkg::REG_COLS_B;
        cfg_wdata <= cb;
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_op = op;
        cur_ra = ra;
        cur_ca = ca;
        cur_rb = rb;
        cur_cb = cb;
    endtask

    // Element value for a given fill style. The symmetric style depends only
    // on the unordered pair of indexes; the upper style zeros the lower part.
    function automatic logic [31:0] fill_value(int style, int r, int c,
                                               logic [31:0] seed);
        int lo, hi;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        case (style)
            0:       return $urandom;
            1:       return $urandom_range(0, 6) - 3;
            2:       return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:       return seed + lo * 7 + hi * 3 + lo * hi;
            default: return (r > c) ? 32'd0 : ((seed[0]) ? $urandom : $urandom_range(0, 5));
        endcase
    endfunction

    task automatic load_matrix(logic [1:0] func, int rows, int cols, int style);
        logic [31:0] seed;
        seed = $urandom_range(0, 9);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                send_item(func, r, c, fill_value(style, r, c, seed));
    endtask

    function automatic logic [4:0] pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return 5'($urandom_range(1, 4));
        if (roll < 94) return 5'($urandom_range(5, 8));
        if (roll < 97) return 5'd0;
        if (roll < 99) return 5'($urandom_range(9, 16));
        return 5'($urandom_range(17, 31));
    endfunction

    // A raw register value that clamps to the same dimension as d, so that
    // matching sizes are sometimes written in different ways.
    function automatic logic [4:0] same_dim(logic [4:0] d);
        if (clamp_dim(d) == 1) return ($urandom_range(0, 1)) ? 5'd0 : 5'd1;
        if (clamp_dim(d) == Dim) return 5'($urandom_range(16, 31));
        return d;
    endfunction

    // One random round: settings, operands, compute, read-back.
    task automatic random_round();
        logic [1:0] op;
        logic [4:0] ra, ca, rb, cb;
        int style_a, style_b, lines;
        op = 2'($urandom_range(0, 3));
        ra = pick_dim();
        ca = ($urandom_range(0, 2) == 0) ? ra : pick_dim();
        if (op[1]) begin
            rb = same_dim(ca);
            cb = ($urandom_range(0, 2) == 0) ? ra : pick_dim();
        end else begin
            rb = same_dim(ra);
            cb = same_dim(ca);
        end
        // About one round in six bumps rb so the dimensions disagree, unless rb was zero.
        if ($urandom_range(0, 5) == 0) rb = (clamp_dim(rb) == Dim) ? 5'd3 : rb + 5'd1;
        set_regs(op, ra, ca, rb, cb);
        style_a = $urandom_range(0, 4);
        style_b = ($urandom_range(0, 1)) ? style_a : $urandom_range(0, 4);
        load_matrix(mase_pkg::FUNC_WRITE_A, clamp_dim(ra), clamp_dim(ca), style_a);
        load_matrix(mase_pkg::FUNC_WRITE_B, clamp_dim(rb), clamp_dim(cb), style_b);
        // Stray writes anywhere in the stores.
        repeat ($urandom_range(0, 2))
            send_item(2'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        lines = $urandom_range(0, 2);
        for (int n = 0; n < lines; n++)
            if (clamp_dim(ra) == clamp_dim(ca))
                send_item(mase_pkg::FUNC_WRITE_A, $urandom_range(0, clamp_dim(ra) - 1),
                          $urandom_range(0, clamp_dim(ca) - 1), 32'd0);
        compute();
        read_back($urandom_range(2, 10));
        if ($urandom_range(0, 3) == 0) compute();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_index   = mase_pkg::REG_OPERATION;
        cfg_wdata   = '0;
        items_sent  = 0;
        burst_left  = 0;
        cur_op      = mase_pkg::OP_MUL;
        cur_ra      = 5'd1;
        cur_ca      = 5'd1;
        cur_rb      = 5'd1;
        cur_cb      = 5'd1;
        for (int i = 0; i < 256; i++) begin
            r_valid[i] = 1'b0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Reset settings multiply 1x1 by 1x1: extreme values
        // and the far corner of both operand stores.
        send_item(mase_pkg::FUNC_WRITE_A, 0, 0, 32'h7FFF_FFFF);
        send_item(mase_pkg::FUNC_WRITE_B, 0, 0, 32'h7FFF_FFFF);
        compute();
        send_item(mase_pkg::FUNC_READ, 0, 0, 32'hFFFF_FFFF);
        send_item(mase_pkg::FUNC_WRITE_A, 15, 15, 32'h8000_0000);
        send_item(mase_pkg::FUNC_WRITE_B, 15, 15, 32'hFFFF_FFFF);
        send_item(mase_pkg::FUNC_WRITE_A, 0, 0, 32'h8000_0000);
        send_item(mase_pkg::FUNC_WRITE_B, 0, 0, 32'hFFFF_FFFF);
        compute();
        send_item(mase_pkg::FUNC_READ, 0, 0, 32'd0);
        // Add of 1x2 matrices, with a row register of zero acting as one:
        // a non-square result that is trivially upper triangular.
        set_regs(mase_pkg::OP_ADD, 5'd0, 5'd2, 5'd1, 5'd2);
        send_item(mase_pkg::FUNC_WRITE_A, 0, 1, 32'hFFFF_FFFF);
        send_item(mase_pkg::FUNC_WRITE_B, 0, 1, 32'h0000_0001);
        compute();
        send_item(mase_pkg::FUNC_READ, 0, 1, 32'd0);
        send_item(mase_pkg::FUNC_READ, 0, 0, 32'd0);
        // Subtract with mismatched rows: error flag set, the other flags clear, result store kept.
        set_regs(mase_pkg::OP_SUB, 5'd1, 5'd1, 5'd2, 5'd1);
        compute();
        send_item(mase_pkg::FUNC_READ, 0, 1, 32'd0);
        // Operation code three acts as multiply; a good compute clears the
        // mismatch flag again.
        set_regs(OpAlias, 5'd1, 5'd1, 5'd1, 5'd1);
        compute();
        send_item(mase_pkg::FUNC_READ, 0, 0, 32'd0);

        // Random part: one round at the largest size, then mostly small ones.
        set_regs(mase_pkg::OP_MUL, 5'd16, 5'd31, 5'd16, 5'd16);
        load_matrix(mase_pkg::FUNC_WRITE_A, Dim, Dim, 1);
        load_matrix(mase_pkg::FUNC_WRITE_B, Dim, Dim, 0);
        compute();
        read_back(8);
        while (items_sent < TargetItems) random_round();

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
